FILE: rtl/schr_pkg.sv
package schr_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned STATE_W     = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BUS_OFF = 2'd1,
    OP_STATE   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REC_LEVEL1 = 1'b0,
    CFG_REC_LEVEL2 = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t                op;
    logic [STATE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                   is_entry;
    logic                   recorded;
    logic [STATE_W-1:0]     entry_state;
    logic [TIME_W-1:0]      entry_time;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic                   last;
  } out_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

endpackage

FILE: rtl/state_change_history_ring.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | schr_pkg::in_t  (op, value)
// out     | output    | out_valid/out_ready | schr_pkg::out_t (entry and status fields)
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata (no wait, no read-back)
//
// tick, bus-off and state ops each give one transfer from the output register
// a read gives DEPTH transfers, one per cycle when out_ready stays high, paced by the
// registered read of the single-port entry memory (one read issued per transfer loaded)
// input is taken only while no read walk is running and the output register is free or draining
// rst_n is synchronous, active low; slot valid bits clear at once, so no clearing pass
// a stalled output holds its transfer and the pending memory read data until out_ready rises
module state_change_history_ring #(
  parameter int unsigned DEPTH = schr_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  schr_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output schr_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [schr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [schr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // slot just below s, wrapping round at the bottom
  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] s);
    return (s == '0) ? LAST_SLOT : s - AW'(1);
  endfunction

  // entry memory: state code and time stamp per slot
  schr_pkg::entry_t                 mem [DEPTH];
  schr_pkg::entry_t                 rd_q_r;
  logic                             rd_vld_q_r;
  logic [DEPTH-1:0]                 vld_r;

  state_t                           state_r, state_nxt;
  logic [AW-1:0]                    wr_slot_r, wr_slot_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             bus_off_r, bus_off_nxt;
  logic [schr_pkg::TIME_W-1:0]      time_r, time_nxt;
  logic [schr_pkg::STATE_W-1:0]     last_state_r, last_state_nxt;
  logic [schr_pkg::STATE_W-1:0]     lvl1_r, lvl2_r;
  logic [AW-1:0]                    rd_slot_r, rd_slot_nxt;
  logic [CW-1:0]                    rd_left_r, rd_left_nxt;
  logic                             out_valid_r, out_valid_nxt;
  schr_pkg::out_t                   out_data_r, out_data_nxt;

  logic                             in_xfer;
  logic                             out_free;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;
  logic                             wr_en;
  logic                             is_rec;
  logic                             allow;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // recovery codes are accepted only during bus-off, others only outside it, and never a repeat of the last state
  assign is_rec = (in_data.value == lvl1_r) || (in_data.value == lvl2_r);
  assign allow  = (bus_off_r ? is_rec : !is_rec) && (in_data.value != last_state_r);

  always_comb begin
    state_nxt      = state_r;
    wr_slot_nxt    = wr_slot_r;
    cnt_nxt        = cnt_r;
    bus_off_nxt    = bus_off_r;
    time_nxt       = time_r;
    last_state_nxt = last_state_r;
    rd_slot_nxt    = rd_slot_r;
    rd_left_nxt    = rd_left_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    rd_addr        = rd_slot_r;
    wr_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_data.op)
            schr_pkg::OP_READ: begin
              // first read goes out now, walk continues one slot lower each transfer
              rd_en       = 1'b1;
              rd_addr     = prev_slot(wr_slot_r);
              rd_slot_nxt = prev_slot(prev_slot(wr_slot_r));
              rd_left_nxt = DEPTH_CNT;
              state_nxt   = S_READ;
            end
            default: begin
              if (in_data.op == schr_pkg::OP_TICK) begin
                time_nxt = time_r + schr_pkg::TIME_W'(1);
              end else if (in_data.op == schr_pkg::OP_BUS_OFF) begin
                bus_off_nxt = in_data.value[0];
              end else if (allow) begin
                wr_en          = 1'b1;
                last_state_nxt = in_data.value;
                wr_slot_nxt    = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + AW'(1);
                if (cnt_r < DEPTH_CNT) begin
                  cnt_nxt = cnt_r + CW'(1);
                end
              end
              out_valid_nxt             = 1'b1;
              out_data_nxt.is_entry     = 1'b0;
              out_data_nxt.recorded     = wr_en;
              out_data_nxt.entry_state  = '0;
              out_data_nxt.entry_time   = '0;
              out_data_nxt.stored_count = schr_pkg::COUNT_OUT_W'(cnt_nxt);
              out_data_nxt.last         = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // read data of the current slot sits in rd_q_r until the output takes it
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.is_entry     = 1'b1;
          out_data_nxt.recorded     = 1'b0;
          out_data_nxt.entry_state  = rd_vld_q_r ? rd_q_r.state : '0;
          out_data_nxt.entry_time   = rd_vld_q_r ? rd_q_r.stamp : '0;
          out_data_nxt.stored_count = schr_pkg::COUNT_OUT_W'(cnt_r);
          out_data_nxt.last         = (rd_left_r == CW'(1));
          rd_left_nxt               = rd_left_r - CW'(1);
          if (rd_left_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = rd_slot_r;
            rd_slot_nxt = prev_slot(rd_slot_r);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // single-port entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot_r] <= '{state: in_data.value, stamp: time_r};
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      rd_vld_q_r <= vld_r[rd_addr];
    end
  end

  // control state, slot valid bits, recovery codes and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wr_slot_r    <= '0;
      cnt_r        <= '0;
      bus_off_r    <= 1'b0;
      time_r       <= '0;
      last_state_r <= '0;
      lvl1_r       <= schr_pkg::STATE_W'(1);
      lvl2_r       <= schr_pkg::STATE_W'(2);
      vld_r        <= '0;
      rd_slot_r    <= '0;
      rd_left_r    <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      wr_slot_r    <= wr_slot_nxt;
      cnt_r        <= cnt_nxt;
      bus_off_r    <= bus_off_nxt;
      time_r       <= time_nxt;
      last_state_r <= last_state_nxt;
      rd_slot_r    <= rd_slot_nxt;
      rd_left_r    <= rd_left_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
      if (wr_en) begin
        vld_r[wr_slot_r] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          schr_pkg::CFG_REC_LEVEL1: lvl1_r <= cfg_wdata;
          schr_pkg::CFG_REC_LEVEL2: lvl2_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("stored count above depth");

  // a non-read op yields a single final status transfer next cycle
  a_status_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.op != schr_pkg::OP_READ)
      |=> out_valid_r && out_data_r.last && !out_data_r.is_entry)
    else $error("missing status transfer");

  // a read starts a walk and blocks further input
  a_read_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.op == schr_pkg::OP_READ) |=> (state_r == S_READ) && !in_ready)
    else $error("read walk not started");

  // a recorded notify always leaves a nonzero count
  a_recorded_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.recorded |-> cnt_r != '0)
    else $error("recorded with empty count");

endmodule

FILE: tb/state_change_history_ring_test.sv
module state_change_history_ring_test;
  timeunit 1ns;
  timeprecision 1ps;

  import schr_pkg::*;

  localparam int unsigned RING_DEPTH   = DEPTH_DEF;
  // the block has a registered output and a registered memory read,
  // the spare drain cycles after the last transfer cover both
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned MAX_REPORTS  = 10;

  // mirror of the history ring: its own copy of the slots, write pointer, fill count,
  // flag, time counter and recovery codes, plus the queue of expected transfers
  class history_ring_mirror;
    bit [STATE_W-1:0]     slot_state [RING_DEPTH];
    bit [TIME_W-1:0]      slot_time  [RING_DEPTH];
    int unsigned          write_ptr;
    int unsigned          fill_count;
    bit                   bus_off;
    bit [TIME_W-1:0]      tick_count;
    bit [STATE_W-1:0]     code1;
    bit [STATE_W-1:0]     code2;
    out_t                 pending_results [$];
    int unsigned          failures;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = '0;
        slot_time[i]  = '0;
      end
      write_ptr  = 0;
      fill_count = 0;
      bus_off    = 1'b0;
      tick_count = '0;
      code1      = 8'd1;
      code2      = 8'd2;
      failures   = 0;
    endfunction

    function void set_codes(input bit [STATE_W-1:0] c1, input bit [STATE_W-1:0] c2);
      code1 = c1;
      code2 = c2;
    endfunction

    // note one accepted request and queue the transfers it causes
    function void take_request(input in_t item);
      out_t        res;
      int unsigned idx;
      int unsigned newest;
      bit          is_recovery;
      bit          allow;
      res = '0;
      if (item.op == OP_READ) begin
        idx = write_ptr;
        for (int k = 0; k < RING_DEPTH; k++) begin
          idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
          res.is_entry     = 1'b1;
          res.recorded     = 1'b0;
          res.entry_state  = slot_state[idx];
          res.entry_time   = slot_time[idx];
          res.stored_count = COUNT_OUT_W'(fill_count);
          res.last         = (k == RING_DEPTH - 1);
          pending_results.push_back(res);
        end
      end else begin
        if (item.op == OP_TICK) begin
          tick_count = tick_count + 1'b1;
        end else if (item.op == OP_BUS_OFF) begin
          bus_off = item.value[0];
        end else begin
          is_recovery = (item.value == code1) || (item.value == code2);
          allow       = bus_off ? is_recovery : !is_recovery;
          newest      = (write_ptr == 0) ? RING_DEPTH - 1 : write_ptr - 1;
          if (slot_state[newest] == item.value) begin
            allow = 1'b0;
          end
          if (allow) begin
            slot_state[write_ptr] = item.value;
            slot_time[write_ptr]  = tick_count;
            write_ptr = (write_ptr == RING_DEPTH - 1) ? 0 : write_ptr + 1;
            if (fill_count < RING_DEPTH) begin
              fill_count++;
            end
            res.recorded = 1'b1;
          end
        end
        res.stored_count = COUNT_OUT_W'(fill_count);
        res.last         = 1'b1;
        pending_results.push_back(res);
      end
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_transfer(input out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("%0t: output transfer with nothing expected: state=%0h time=%0h",
                   $realtime, got.entry_state, got.entry_time);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.is_entry !== want.is_entry || got.recorded !== want.recorded ||
            got.entry_state !== want.entry_state || got.entry_time !== want.entry_time ||
            got.stored_count !== want.stored_count || got.last !== want.last) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected entry=%0b rec=%0b state=%0h time=%0h cnt=%0d last=%0b",
                     $realtime, want.is_entry, want.recorded, want.entry_state,
                     want.entry_time, want.stored_count, want.last);
            $display("%0t:           actual   entry=%0b rec=%0b state=%0h time=%0h cnt=%0d last=%0b",
                     $realtime, got.is_entry, got.recorded, got.entry_state,
                     got.entry_time, got.stored_count, got.last);
          end
        end
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // idle rates in percent of cycles, changed per phase
  int unsigned            send_idle_pct  = 0;
  int unsigned            recv_stall_pct = 0;

  history_ring_mirror     board = new();

  state_change_history_ring #(
    .DEPTH (RING_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver side: check the transfer seen at this edge, then pick the next
  // ready level according to the current stall rate
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_transfer(out_data);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // offer one request, with random idle cycles first, and wait until it is accepted
  task automatic send_item(input in_t item);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    board.take_request(item);
  endtask

  task automatic send_op(input op_t op, input logic [STATE_W-1:0] value);
    in_t item;
    item.op    = op;
    item.value = value;
    send_item(item);
  endtask

  // drop valid, wait for every expected transfer, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both recovery codes, one per edge, only while the block is idle
  task automatic write_codes(input logic [STATE_W-1:0] c1, input logic [STATE_W-1:0] c2);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REC_LEVEL1;
    cfg_wdata <= c1;
    @(posedge clk);
    cfg_index <= CFG_REC_LEVEL2;
    cfg_wdata <= c2;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_codes(c1, c2);
  endtask

  // random request: mostly state notifies that fit the bus-off flag, so the
  // ring fills, wraps and saturates; ticks, bus-off toggles, reads and
  // unfit codes in between
  function automatic in_t random_item();
    in_t         item;
    int unsigned roll;
    roll       = $urandom_range(0, 99);
    item.value = 8'($urandom);
    if (roll < 15) begin
      item.op = OP_TICK;
    end else if (roll < 27) begin
      item.op = OP_BUS_OFF;
    end else if (roll < 90) begin
      item.op = OP_STATE;
      roll    = $urandom_range(0, 99);
      if (roll < (board.bus_off ? 65 : 12)) begin
        item.value = $urandom_range(0, 1) ? board.code1 : board.code2;
      end else if (roll < 80) begin
        item.value = 8'($urandom_range(0, 5));
      end
    end else begin
      item.op = OP_READ;
    end
    return item;
  endfunction

  initial begin
    // synchronous reset held first, inputs already at known values
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with reset codes 1 and 2, no idling
    send_op(OP_READ,    8'h00);  // empty ring reads back all zero
    send_op(OP_STATE,   8'h00);  // state 0 into a cleared ring is no change
    send_op(OP_STATE,   8'h01);  // recovery code while bus-off clear, dropped
    send_op(OP_TICK,    8'hFF);  // value ignored on tick
    send_op(OP_STATE,   8'h05);
    send_op(OP_STATE,   8'h05);  // repeat of newest slot, dropped
    send_op(OP_BUS_OFF, 8'hFE);  // upper bits ignored, flag stays clear
    send_op(OP_BUS_OFF, 8'h01);
    send_op(OP_STATE,   8'h07);  // plain code while bus-off set, dropped
    send_op(OP_STATE,   8'h02);
    send_op(OP_STATE,   8'h01);
    send_op(OP_STATE,   8'h01);
    send_op(OP_BUS_OFF, 8'hFF);
    send_op(OP_STATE,   8'hFF);
    send_op(OP_BUS_OFF, 8'h00);
    send_op(OP_TICK,    8'h00);
    send_op(OP_STATE,   8'hFF);
    send_op(OP_STATE,   8'h00);
    send_op(OP_STATE,   8'h02);
    send_op(OP_READ,    8'hA5);  // value ignored on read
    drain();

    // random phases, each with its own code setting and idle pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_codes(8'd1, 8'd2);
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          write_codes(8'd0, 8'd255);
          send_idle_pct  = 72;
          recv_stall_pct <= 0;
        end
        2: begin
          // both codes equal
          write_codes(8'd255, 8'd255);
          send_idle_pct  = 0;
          recv_stall_pct <= 72;
        end
        default: begin
          write_codes(8'($urandom), 8'($urandom));
          send_idle_pct  = 17;
          recv_stall_pct <= 17;
        end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item());
      drain();
    end

    if (board.failures == 0 && board.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/schr_pkg.sv
rtl/state_change_history_ring.sv
tb/state_change_history_ring_test.sv
